/* design/keyed_sine_tone_generator_assert.svh */
// Assertion macros for the keyed sine tone generator.
// Used by the top level; expects aclk and aresetn in scope.
`ifndef KEYED_SINE_TONE_GENERATOR_ASSERT_SVH
`define KEYED_SINE_TONE_GENERATOR_ASSERT_SVH
`ifndef ASSERT_OFF
`define KSTG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define KSTG_ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) else $error(msg);
`else
`define KSTG_ASSERT(label, prop, msg)
`define KSTG_ASSERT_NEVER(label, expr, msg)
`endif
`endif

/* design/kstg_pkg.sv */
// Shared types, tables and functions for the keyed sine tone generator.
// No dependencies.
package kstg_pkg;

    localparam int SAMPLES_PER_CYCLE = 24;
    localparam int DAC_BITS          = 12;
    localparam int NOTE_COUNT        = 35;
    localparam int WAIT_DEPTH        = 256;

    localparam logic [7:0] KEY_OCT4 = 8'h7A;
    localparam logic [7:0] KEY_OCT2 = 8'h78;
    localparam logic [7:0] KEY_OCT1 = 8'h63;

    localparam logic [1:0] SHIFT_X1 = 2'd0;
    localparam logic [1:0] SHIFT_X2 = 2'd1;
    localparam logic [1:0] SHIFT_X4 = 2'd2;

    localparam logic [5:0] NOTE_SILENT = 6'd0;
    localparam logic [4:0] POS_LAST    = 5'(SAMPLES_PER_CYCLE - 1);

    typedef logic [8:0]      wait_cnt_t;
    typedef logic [DAC_BITS-1:0] sample_t;
    typedef wait_cnt_t       wait_table_t [WAIT_DEPTH];

    typedef struct packed {
        logic       en;
        logic [7:0] addr;
    } wait_rd_t;

    localparam sample_t SINE_ROM [SAMPLES_PER_CYCLE] = '{
        12'd2047, 12'd2577, 12'd3070, 12'd3494, 12'd3820, 12'd4024,
        12'd4094, 12'd4024, 12'd3820, 12'd3494, 12'd3070, 12'd2577,
        12'd2047, 12'd1517, 12'd1023, 12'd599,  12'd274,  12'd70,
        12'd0,    12'd70,   12'd274,  12'd600,  12'd1023, 12'd1517
    };

    localparam logic [7:0] NOTE_KEYS [NOTE_COUNT] = '{
        8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h71, 8'h77,
        8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70,
        8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A, 8'h28, 8'h29,
        8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h30
    };

    localparam logic [10:0] NOTE_PERIODS [NOTE_COUNT] = '{
        11'd454,  11'd405,  11'd382,  11'd340,  11'd303,  11'd286, 11'd255,
        11'd227,  11'd202,  11'd191,  11'd170,  11'd151,  11'd143, 11'd127, 11'd114,
        11'd1716, 11'd1443, 11'd1286, 11'd1081, 11'd963,  11'd858, 11'd722,
        11'd643,  11'd540,  11'd482,
        11'd429,  11'd361,  11'd321,  11'd270,  11'd241,  11'd214, 11'd180,
        11'd161,  11'd135,  11'd120
    };

    function automatic logic [5:0] note_of_key(input logic [7:0] key);
        logic [5:0] note;
        note = NOTE_SILENT;
        for (int n = 0; n < NOTE_COUNT; n++) begin
            if (NOTE_KEYS[n] == key) begin
                note = 6'(n + 1);
            end
        end
        return note;
    endfunction

    function automatic sample_t sine_at(input logic [4:0] pos);
        sample_t s;
        if (pos < 5'(SAMPLES_PER_CYCLE)) begin
            s = SINE_ROM[pos];
        end else begin
            s = SINE_ROM[0];
        end
        return s;
    endfunction

    // floor(period * mult / 24) as ((x >> 3) * 683) >> 11, exact for x < 8192
    function automatic wait_cnt_t wait_ticks(input logic [5:0] note, input logic [1:0] shift);
        logic [10:0] period;
        logic [12:0] scaled;
        logic [19:0] prod;
        logic [1:0]  sh;
        period = '0;
        if (note != NOTE_SILENT && note <= 6'(NOTE_COUNT)) begin
            period = NOTE_PERIODS[note - 6'd1];
        end
        sh     = (shift > SHIFT_X4) ? SHIFT_X4 : shift;
        scaled = {2'b00, period} << sh;
        prod   = 20'(scaled[12:3]) * 20'd683;
        return prod[19:11];
    endfunction

    function automatic wait_table_t build_wait_table();
        wait_table_t t;
        for (int a = 0; a < WAIT_DEPTH; a++) begin
            t[a] = wait_ticks(6'(a % 64), 2'(a / 64));
        end
        return t;
    endfunction

endpackage

/* design/kstg_wait_rom.sv */
// Synchronous ROM of wait tick counts, addressed by {octave shift, note}.
// Depends on kstg_pkg.
module kstg_wait_rom (
    input  logic                 aclk,
    input  kstg_pkg::wait_rd_t   rd,
    output kstg_pkg::wait_cnt_t  rd_data
);

    localparam kstg_pkg::wait_table_t WAIT_ROM = kstg_pkg::build_wait_table();

    kstg_pkg::wait_cnt_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (rd.en) begin
            rd_data_reg <= WAIT_ROM[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/keyed_sine_tone_generator.sv */
// Keyed sine tone generator top level: key/tick input channel, DAC word output.
// Depends on kstg_pkg, kstg_wait_rom and keyed_sine_tone_generator_assert.svh.
//
// Input words carry s_kind (0 = key byte in s_key_code, 1 = time tick).
// Key words only update the held key and never produce output.
// A tick either counts down a pending wait, or at a cycle boundary or while
// silent acts on the held key: z, x, c set the octave (x4, x2, x1) and go
// silent, a note key starts a 24-sample sine cycle, anything else stays silent.
// Each emitted sample gives one output word: m_dac_word holds the command
// nibble (cfg_wdata, reset 7) over the 12-bit sample, plus m_sample_index
// and m_cycle_last. The wait tick count after each sample comes from a
// synchronous ROM read in the emitting cycle and is used by the next tick.
// m_valid is registered and rises in the cycle after an accepted emitting tick.
// Throughput: one input word per cycle; s_ready drops only while the output
// register is full and m_ready is low.
// Reset clears control state to silent, octave x1, command nibble 7 (not output data).
module keyed_sine_tone_generator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_kind,
    input  logic [7:0]  s_key_code,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_dac_word,
    output logic [4:0]  m_sample_index,
    output logic        m_cycle_last
);

    logic [3:0]  nibble_reg, nibble_next;
    logic [7:0]  held_key_reg, held_key_next;
    logic [5:0]  note_reg, note_next;
    logic [1:0]  shift_reg, shift_next;
    logic [4:0]  pos_reg, pos_next;
    kstg_pkg::wait_cnt_t wait_left_reg, wait_left_next;
    logic        load_pend_reg, load_pend_next;
    logic        m_valid_reg, m_valid_next;
    logic [15:0] dac_word_reg, dac_word_next;
    logic [4:0]  index_reg, index_next;
    logic        last_reg, last_next;

    logic                fire;
    logic                decide;
    logic                emit;
    logic [5:0]          new_note;
    logic [1:0]          new_shift;
    logic [1:0]          shift_eff;
    logic [4:0]          pos_cur;
    kstg_pkg::wait_cnt_t wait_eff;
    kstg_pkg::wait_cnt_t rom_data;
    kstg_pkg::wait_rd_t  rom_rd;

    kstg_wait_rom u_wait_rom (
        .aclk    (aclk),
        .rd      (rom_rd),
        .rd_data (rom_data)
    );

    assign s_ready = !m_valid_reg || m_ready;
    assign fire    = s_valid && s_ready;

    always_comb begin
        wait_eff = load_pend_reg ? rom_data : wait_left_reg;
        decide   = (pos_reg == 5'd0) || (note_reg == kstg_pkg::NOTE_SILENT);
        new_note  = note_reg;
        new_shift = shift_reg;
        if (decide) begin
            case (held_key_reg)
                kstg_pkg::KEY_OCT4: begin
                    new_shift = kstg_pkg::SHIFT_X4;
                    new_note  = kstg_pkg::NOTE_SILENT;
                end
                kstg_pkg::KEY_OCT2: begin
                    new_shift = kstg_pkg::SHIFT_X2;
                    new_note  = kstg_pkg::NOTE_SILENT;
                end
                kstg_pkg::KEY_OCT1: begin
                    new_shift = kstg_pkg::SHIFT_X1;
                    new_note  = kstg_pkg::NOTE_SILENT;
                end
                default: begin
                    new_note = kstg_pkg::note_of_key(held_key_reg);
                end
            endcase
        end
        shift_eff = (new_shift > kstg_pkg::SHIFT_X4) ? kstg_pkg::SHIFT_X4 : new_shift;
        pos_cur   = decide ? 5'd0 : pos_reg;
        emit      = fire && s_kind && (wait_eff == '0) && (new_note != kstg_pkg::NOTE_SILENT);

        rom_rd.en   = emit;
        rom_rd.addr = {shift_eff, new_note};

        nibble_next    = cfg_we ? cfg_wdata : nibble_reg;
        held_key_next  = held_key_reg;
        note_next      = note_reg;
        shift_next     = shift_reg;
        pos_next       = pos_reg;
        wait_left_next = wait_left_reg;
        load_pend_next = load_pend_reg;

        if (fire && !s_kind) begin
            held_key_next = s_key_code;
        end
        if (fire && s_kind) begin
            if (wait_eff != '0) begin
                wait_left_next = wait_eff - 9'd1;
                load_pend_next = 1'b0;
            end else begin
                note_next      = new_note;
                shift_next     = new_shift;
                pos_next       = pos_cur;
                wait_left_next = '0;
                load_pend_next = 1'b0;
                if (emit) begin
                    pos_next       = (pos_cur == kstg_pkg::POS_LAST) ? 5'd0 : pos_cur + 5'd1;
                    load_pend_next = 1'b1;
                end
            end
        end

        m_valid_next  = m_valid_reg;
        dac_word_next = dac_word_reg;
        index_next    = index_reg;
        last_next     = last_reg;
        if (emit) begin
            m_valid_next  = 1'b1;
            dac_word_next = {nibble_reg, kstg_pkg::sine_at(pos_cur)};
            index_next    = pos_cur;
            last_next     = (pos_cur == kstg_pkg::POS_LAST);
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nibble_reg    <= 4'd7;
            held_key_reg  <= '0;
            note_reg      <= kstg_pkg::NOTE_SILENT;
            shift_reg     <= kstg_pkg::SHIFT_X1;
            pos_reg       <= '0;
            wait_left_reg <= '0;
            load_pend_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            nibble_reg    <= nibble_next;
            held_key_reg  <= held_key_next;
            note_reg      <= note_next;
            shift_reg     <= shift_next;
            pos_reg       <= pos_next;
            wait_left_reg <= wait_left_next;
            load_pend_reg <= load_pend_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        dac_word_reg <= dac_word_next;
        index_reg    <= index_next;
        last_reg     <= last_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_dac_word     = dac_word_reg;
    assign m_sample_index = index_reg;
    assign m_cycle_last   = last_reg;

`include "keyed_sine_tone_generator_assert.svh"

    `KSTG_ASSERT_NEVER(a_pos_range, pos_reg > kstg_pkg::POS_LAST, "sample position out of range")
    `KSTG_ASSERT(a_pend_note, load_pend_reg |-> (note_reg != kstg_pkg::NOTE_SILENT), "wait load while silent")
    `KSTG_ASSERT(a_last_index, m_valid |-> (m_cycle_last == (m_sample_index == kstg_pkg::POS_LAST)), "cycle_last mismatch")
    `KSTG_ASSERT(a_emit_load, emit |=> load_pend_reg, "wait load not armed after sample")

endmodule
